>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the edge magnitude unit checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> design/gem_pkg.sv
// ----------------------------------------------------------------------------
// gem_pkg
// Shared types and constants of the gradient edge magnitude unit.
// ----------------------------------------------------------------------------
package gem_pkg;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int PIX_W         = 8;
	localparam int GRAD_W        = 11;
	localparam int HEIGHT_W      = 16;
	localparam int WIDTH_W       = 11;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 16;

	localparam logic [PIX_W-1:0] PIX_MAX  = 8'hFF;
	localparam logic [PIX_W-1:0] PIX_ZERO = 8'h00;

	localparam logic [CFG_IDX_W-1:0] CFG_EDGE_MODE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

	localparam logic       MODE_ROBERTS   = 1'b0;
	localparam logic       MODE_PREWITT   = 1'b1;
	localparam logic       KIND_PAD       = 1'b1;

	// Signed gradient pair handed from front to back.
	typedef struct packed {
		logic signed [GRAD_W-1:0] gx;
		logic signed [GRAD_W-1:0] gy;
		logic                     last;
	} grad_item_t;

endpackage

>>> design/gem_ram.sv
// ----------------------------------------------------------------------------
// gem_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gem_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> design/gem_front.sv
// ----------------------------------------------------------------------------
// gem_front
// Accepts pixels, keeps row stores, window and raster position, and
// produces the signed gradient pair of each result.
// ----------------------------------------------------------------------------
module gem_front #(
	parameter int MAX_WIDTH = gem_pkg::MAX_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [gem_pkg::PIX_W-1:0]         s_tdata,
	input  logic                              s_tuser,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [gem_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gem_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic                              push,
	output gem_pkg::grad_item_t               push_data,
	input  logic                              q_full
);

	import gem_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = CW + 1;
	localparam int RW = HEIGHT_W + 1;

	typedef enum logic [1:0] {
		F_IDLE = 2'b01,
		F_EXEC = 2'b10
	} front_state_t;

	front_state_t         state_q;
	logic                 mode_q;
	logic [WIDTH_W-1:0]   width_q;
	logic [HEIGHT_W-1:0]  height_q;
	logic [CW-1:0]        col_q;
	logic [RW-1:0]        row_q;
	logic [PIX_W-1:0]     win_q [3][3];
	logic                 kind_q;
	logic [PIX_W-1:0]     pix_q;

	logic [2*PIX_W-1:0]   rd_word;
	logic [PIX_W-1:0]     up, up2, px, ul, lf, uu;
	logic [31:0]          w32;
	logic [WW-1:0]        w_eff, c_ext, c_next, cc;
	logic [RW-1:0]        h_eff, cr;
	logic                 c_nz, r_nz, wrap, valid_p, top0, bot0, lft0, rgt0;
	logic                 end_r, end_p, is_end, has_res, proceed, s_accept;
	logic [PIX_W-1:0]     nw [3][3];
	logic [PIX_W-1:0]     m [3][3];
	logic [GRAD_W-1:0]    sum_r, sum_l, sum_b, sum_t;
	logic signed [GRAD_W-1:0] rob_gx, rob_gy;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == F_IDLE);
	assign s_accept  = s_tvalid && s_tready;
	assign proceed   = (state_q == F_EXEC) && !q_full;

	gem_ram #(
		.WIDTH (2*PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_rows (
		.clk   (clk),
		.we    (proceed),
		.waddr (col_q),
		.wdata ({px, up}),
		.re    (s_accept),
		.raddr (col_q),
		.rdata (rd_word)
	);

	// Upper byte holds the previous row, lower byte the row before it.
	assign up  = rd_word[2*PIX_W-1:PIX_W];
	assign up2 = rd_word[PIX_W-1:0];

	always_comb begin
		if (width_q == '0) begin
			w32 = 32'd1;
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			w32 = 32'(MAX_WIDTH);
		end else begin
			w32 = 32'(width_q);
		end
	end
	assign w_eff = w32[WW-1:0];
	assign h_eff = (height_q == '0) ? RW'(1) : {1'b0, height_q};

	assign c_ext  = {1'b0, col_q};
	assign c_next = c_ext + 1'b1;
	assign wrap   = (c_next >= w_eff);
	assign c_nz   = (col_q != '0);
	assign r_nz   = (row_q != '0);

	assign px = (kind_q || row_q >= h_eff) ? PIX_ZERO : pix_q;
	assign ul = (c_nz && r_nz) ? win_q[1][2] : PIX_ZERO;
	assign lf = c_nz ? win_q[2][2] : PIX_ZERO;
	assign uu = r_nz ? up : PIX_ZERO;

	assign rob_gx = $signed({3'b000, ul}) - $signed({3'b000, px});
	assign rob_gy = $signed({3'b000, uu}) - $signed({3'b000, lf});

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nw[i][0] = win_q[i][1];
			nw[i][1] = win_q[i][2];
		end
		nw[0][2] = up2;
		nw[1][2] = up;
		nw[2][2] = px;
	end

	assign valid_p = c_nz ? (row_q >= RW'(1)) : (row_q >= RW'(2));
	assign cr      = c_nz ? (row_q - RW'(1)) : (row_q - RW'(2));
	assign cc      = c_nz ? (c_ext - WW'(1)) : (w_eff - WW'(1));
	assign top0    = (cr == '0);
	assign bot0    = (cr == h_eff - RW'(1));
	assign lft0    = (cc == '0);
	assign rgt0    = (cc == w_eff - WW'(1));

	// Zero the window taps that fall outside the image.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				if ((i == 0 && top0) || (i == 2 && bot0) ||
				    (j == 0 && lft0) || (j == 2 && rgt0)) begin
					m[i][j] = PIX_ZERO;
				end else begin
					m[i][j] = nw[i][j];
				end
			end
		end
	end

	assign sum_r = GRAD_W'(m[0][2]) + GRAD_W'(m[1][2]) + GRAD_W'(m[2][2]);
	assign sum_l = GRAD_W'(m[0][0]) + GRAD_W'(m[1][0]) + GRAD_W'(m[2][0]);
	assign sum_b = GRAD_W'(m[2][0]) + GRAD_W'(m[2][1]) + GRAD_W'(m[2][2]);
	assign sum_t = GRAD_W'(m[0][0]) + GRAD_W'(m[0][1]) + GRAD_W'(m[0][2]);

	assign end_r   = (row_q == h_eff - RW'(1)) && (c_ext == w_eff - WW'(1));
	assign end_p   = bot0 && rgt0;
	assign has_res = (mode_q == MODE_ROBERTS) ? 1'b1 : valid_p;
	assign is_end  = has_res && ((mode_q == MODE_ROBERTS) ? end_r : end_p);

	always_comb begin
		push_data.last = is_end;
		if (mode_q == MODE_ROBERTS) begin
			push_data.gx = rob_gx;
			push_data.gy = rob_gy;
		end else begin
			push_data.gx = $signed(sum_r - sum_l);
			push_data.gy = $signed(sum_b - sum_t);
		end
	end
	assign push = proceed && has_res;

	// Latch the item; the row store read runs in the same edge.
	always_ff @(posedge clk) begin
		if (s_accept) begin
			kind_q <= s_tuser;
			pix_q  <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= F_IDLE;
			mode_q   <= MODE_PREWITT;
			width_q  <= WIDTH_W'(640);
			height_q <= HEIGHT_W'(480);
			col_q    <= '0;
			row_q    <= '0;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= PIX_ZERO;
				end
			end
		end else begin
			if (cfg_valid && cfg_ready && cfg_index <= CFG_IMAGE_HEIGHT) begin
				case (cfg_index)
					CFG_EDGE_MODE:    mode_q   <= cfg_data[0];
					CFG_IMAGE_WIDTH:  width_q  <= cfg_data[WIDTH_W-1:0];
					CFG_IMAGE_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
				col_q <= '0;
				row_q <= '0;
				for (int i = 0; i < 3; i++) begin
					for (int j = 0; j < 3; j++) begin
						win_q[i][j] <= PIX_ZERO;
					end
				end
			end
			case (state_q)
				F_IDLE: begin
					// Drop a pad tick that arrives between frames.
					if (s_accept && !(s_tuser == KIND_PAD && col_q == '0 && row_q == '0)) begin
						state_q <= F_EXEC;
					end
				end
				F_EXEC: begin
					if (proceed) begin
						state_q <= F_IDLE;
						win_q   <= nw;
						if (is_end) begin
							col_q <= '0;
							row_q <= '0;
						end else if (wrap) begin
							col_q <= '0;
							row_q <= row_q + RW'(1);
						end else begin
							col_q <= c_next[CW-1:0];
						end
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

>>> design/gem_queue.sv
// ----------------------------------------------------------------------------
// gem_queue
// Two-entry queue of gradient pairs between front and back.
// ----------------------------------------------------------------------------
module gem_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  gem_pkg::grad_item_t push_data,
	output logic                full,
	input  logic                pop,
	output logic                not_empty,
	output gem_pkg::grad_item_t head
);

	import gem_pkg::*;

	grad_item_t slot_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

>>> design/gem_back.sv
// ----------------------------------------------------------------------------
// gem_back
// Turns a gradient pair into a saturated magnitude: squares, sum, then a
// bit-per-cycle square root, into the output register.
// ----------------------------------------------------------------------------
module gem_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_valid,
	input  gem_pkg::grad_item_t       q_head,
	output logic                      pop,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [gem_pkg::PIX_W-1:0] m_tdata,
	output logic                      m_tlast
);

	import gem_pkg::*;

	typedef enum logic [4:0] {
		B_IDLE = 5'b00001,
		B_SQ   = 5'b00010,
		B_SUM  = 5'b00100,
		B_ROOT = 5'b01000,
		B_DONE = 5'b10000
	} back_state_t;

	back_state_t          state_q;
	logic [9:0]           ax_q, ay_q;
	logic                 last_q;
	logic [19:0]          sqx_s1, sqy_s1;
	logic [20:0]          v_q;
	logic [PIX_W-1:0]     res_q, bit_q, t;
	logic [15:0]          tt;
	logic [GRAD_W-1:0]    ax_full, ay_full;
	logic                 load;
	logic                 out_valid_q, out_last_q;
	logic [PIX_W-1:0]     out_value_q;

	assign pop     = (state_q == B_IDLE) && q_valid;
	assign ax_full = q_head.gx[GRAD_W-1] ? GRAD_W'(-q_head.gx) : q_head.gx;
	assign ay_full = q_head.gy[GRAD_W-1] ? GRAD_W'(-q_head.gy) : q_head.gy;
	assign t       = res_q | bit_q;
	assign tt      = t * t;
	assign load    = (state_q == B_DONE) && (!out_valid_q || m_tready);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_value_q;
	assign m_tlast  = out_last_q;

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				ax_q   <= ax_full[9:0];
				ay_q   <= ay_full[9:0];
				last_q <= q_head.last;
				res_q  <= PIX_ZERO;
				bit_q  <= 8'h80;
			end
			B_SQ: begin
				sqx_s1 <= ax_q * ax_q;
				sqy_s1 <= ay_q * ay_q;
			end
			B_SUM: begin
				v_q <= 21'(sqx_s1) + 21'(sqy_s1);
			end
			B_ROOT: begin
				if (21'(tt) <= v_q) begin
					res_q <= t;
				end
				bit_q <= bit_q >> 1;
			end
			default: ;
		endcase
		if (load) begin
			out_value_q <= (v_q[20:16] != '0) ? PIX_MAX : res_q;
			out_last_q  <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				B_IDLE: if (q_valid) begin
					state_q <= B_SQ;
				end
				B_SQ:   state_q <= B_SUM;
				B_SUM:  state_q <= B_ROOT;
				B_ROOT: if (bit_q[0]) begin
					state_q <= B_DONE;
				end
				B_DONE: if (load) begin
					state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> design/gradient_edge_magnitude_unit.sv
// ----------------------------------------------------------------------------
// gradient_edge_magnitude_unit
// Raster-order edge magnitude filter, Roberts cross or Prewitt 3x3.
// ----------------------------------------------------------------------------
// Feed 8-bit grey pixels in raster order; each pixel yields one magnitude
// floor(sqrt(gx^2 + gy^2)) saturated at 255, with m_tlast on the last pixel
// of the frame. Roberts results appear per pixel; Prewitt results lag by
// image_width+1 items, so send image_width+1 pad items (s_tuser = 1) after
// a frame to flush the last row. Pad items between frames are dropped.
// The front reads the row store for an item, then updates the window, taking
// no new item in between; a full queue stalls the update. The back end works
// on one result at a time: square, sum and an 8-step bit-serial square root
// before the output register is loaded; a 2-entry queue lets the front run
// ahead. Row stores need no clearing after reset. Write configuration only
// while the unit is idle; any write to a defined register restarts the frame.
// ----------------------------------------------------------------------------
module gradient_edge_magnitude_unit #(
	parameter int MAX_WIDTH = gem_pkg::MAX_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [gem_pkg::PIX_W-1:0]      s_tdata,   // [7:0] pixel
	input  logic                           s_tuser,   // [0] kind: 1 pad item
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [gem_pkg::PIX_W-1:0]      m_tdata,   // [7:0] edge_value
	output logic                           m_tlast,   // frame_end
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [gem_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gem_pkg::CFG_DATA_W-1:0] cfg_data
);

	import gem_pkg::*;

	grad_item_t push_data, head;
	logic       push, full, pop, not_empty;

	// Front: position, window, row stores, gradient pair.
	gem_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.push_data (push_data),
		.q_full    (full)
	);

	// Hold pending gradient pairs while the root unit is busy.
	gem_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	// Back: magnitude and output register.
	gem_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (not_empty),
		.q_head   (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

>>> design/gem_checker.sv
// ----------------------------------------------------------------------------
// gem_checker
// Port-level checks of the edge magnitude unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gem_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [gem_pkg::PIX_W-1:0]      s_tdata,
	input logic                           s_tuser,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [gem_pkg::PIX_W-1:0]      m_tdata,
	input logic                           m_tlast,
	input logic                           cfg_valid,
	input logic                           cfg_ready,
	input logic [gem_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [gem_pkg::CFG_DATA_W-1:0] cfg_data
);

	// A stalled result holds its payload.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
	// The front drops s_tready after each accepted pixel while it updates its
	// window; an idle pad may be dropped without that.
	`ASSERT_NEXT(a_front_busy, clk, arst_n, s_tvalid && s_tready && !s_tuser, !s_tready)
	// Configuration is never back-pressured.
	`ASSERT_HOLDS(a_cfg_ready, clk, arst_n, cfg_ready)
	// No result is shown directly after reset.
	`ASSERT_HOLDS(a_reset_quiet, clk, arst_n, $rose(arst_n) |-> !m_tvalid)

endmodule

bind gradient_edge_magnitude_unit gem_checker u_chk (.*);

>>> bench/gem_checker.sv
// ----------------------------------------------------------------------------
// gem_scoreboard
// Watches the pixel, result and configuration channels of the edge magnitude
// unit, predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module gem_scoreboard (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [gem_pkg::PIX_W-1:0]      s_tdata,
	input  logic                           s_tuser,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [gem_pkg::PIX_W-1:0]      m_tdata,
	input  logic                           m_tlast,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [gem_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gem_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             mismatches,
	output int                             pending,
	output int                             results_seen
);

	import gem_pkg::*;

	typedef struct {
		logic [PIX_W-1:0] edge_value;
		logic             frame_end;
	} edge_result_t;

	edge_result_t      edge_q[$];
	logic [PIX_W-1:0]  prev_row[0:MAX_WIDTH_DEF-1];
	logic [PIX_W-1:0]  prev2_row[0:MAX_WIDTH_DEF-1];
	logic [PIX_W-1:0]  win[0:2][0:2];
	int unsigned       col_pos, row_pos;
	logic              mode;
	int unsigned       width_reg, height_reg;

	function automatic logic [PIX_W-1:0] grad_magnitude(int gx, int gy);
		int unsigned sq, acc, trial;
		sq = gx * gx + gy * gy;
		if (sq >= 65536) return PIX_MAX;
		acc = 0;
		for (int b = 7; b >= 0; b--) begin
			trial = acc | (1 << b);
			if (trial * trial <= sq) acc = trial;
		end
		return acc[PIX_W-1:0];
	endfunction

	task automatic restart_frame();
		col_pos = 0;
		row_pos = 0;
		foreach (win[i, j]) win[i][j] = PIX_ZERO;
	endtask

	// Advance the predicted state by one accepted pixel or pad item.
	task automatic predict_edge(logic pad, logic [PIX_W-1:0] pix_in);
		int unsigned w, h, c, r, cr, cc;
		int          px, up, up2, ul, lf, u, gx, gy;
		int          m[3][3];
		edge_result_t res;
		logic        done;
		w = (width_reg < 1) ? 1 : (width_reg > MAX_WIDTH_DEF ? MAX_WIDTH_DEF : width_reg);
		h = (height_reg < 1) ? 1 : height_reg;
		c = col_pos;
		r = row_pos;
		px = pad ? 0 : pix_in;
		// drop a pad item between frames
		if (pad && c == 0 && r == 0) return;
		if (c >= w) c = w - 1;
		if (r >= h) px = 0;
		up  = prev_row[c];
		up2 = prev2_row[c];
		ul = (c > 0 && r > 0) ? win[1][2] : 0;
		lf = (c > 0) ? win[2][2] : 0;
		u  = (r > 0) ? up : 0;
		gx = ul - px;
		gy = u - lf;
		for (int i = 0; i < 3; i++) begin
			win[i][0] = win[i][1];
			win[i][1] = win[i][2];
		end
		win[0][2] = up2[PIX_W-1:0];
		win[1][2] = up[PIX_W-1:0];
		win[2][2] = px[PIX_W-1:0];
		prev2_row[c] = up[PIX_W-1:0];
		prev_row[c]  = px[PIX_W-1:0];
		col_pos = c + 1;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos = r + 1;
		end
		if (mode == MODE_ROBERTS) begin
			res.edge_value = grad_magnitude(gx, gy);
			done = (r == h - 1 && c == w - 1);
		end else begin
			// the window center trails the input by one row and one column
			if (c > 0) begin
				if (r < 1) return;
				cr = r - 1;
				cc = c - 1;
			end else begin
				if (r < 2) return;
				cr = r - 2;
				cc = w - 1;
			end
			foreach (m[i, j]) m[i][j] = win[i][j];
			for (int i = 0; i < 3; i++) begin
				if (cr == 0) m[0][i] = 0;
				if (cr == h - 1) m[2][i] = 0;
				if (cc == 0) m[i][0] = 0;
				if (cc == w - 1) m[i][2] = 0;
			end
			gx = 0;
			gy = 0;
			for (int i = 0; i < 3; i++) begin
				gx += m[i][2] - m[i][0];
				gy += m[2][i] - m[0][i];
			end
			res.edge_value = grad_magnitude(gx, gy);
			done = (cr == h - 1 && cc == w - 1);
		end
		if (done) begin
			col_pos = 0;
			row_pos = 0;
		end
		res.frame_end = done;
		edge_q.push_back(res);
	endtask

	initial begin
		foreach (prev_row[i]) begin
			prev_row[i]  = PIX_ZERO;
			prev2_row[i] = PIX_ZERO;
		end
		mismatches   = 0;
		results_seen = 0;
		pending      = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		edge_result_t want;
		if (!arst_n) begin
			mode       = MODE_PREWITT;
			width_reg  = 640;
			height_reg = 480;
			restart_frame();
		end else begin
			// compare first: a result never stems from an item taken at the same edge
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (edge_q.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result edge_value=%0d frame_end=%0b",
						$time, m_tdata, m_tlast);
				end else begin
					want = edge_q.pop_front();
					if (m_tdata !== want.edge_value) begin
						mismatches++;
						$display("%0t: edge_value expected %0d actual %0d",
							$time, want.edge_value, m_tdata);
					end
					if (m_tlast !== want.frame_end) begin
						mismatches++;
						$display("%0t: frame_end expected %0b actual %0b",
							$time, want.frame_end, m_tlast);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_EDGE_MODE: begin
						mode = cfg_data[0];
						restart_frame();
					end
					CFG_IMAGE_WIDTH: begin
						width_reg = cfg_data[WIDTH_W-1:0];
						restart_frame();
					end
					CFG_IMAGE_HEIGHT: begin
						height_reg = cfg_data;
						restart_frame();
					end
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				predict_edge(s_tuser == KIND_PAD, s_tdata);
		end
		pending = edge_q.size();
	end

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the gradient edge magnitude unit.
// ----------------------------------------------------------------------------
// Frames of random size are streamed in Roberts and Prewitt modes with pad
// items, bursty input and a stalling output; gem_scoreboard predicts and
// compares every result and reports its mismatch count back here.
// ----------------------------------------------------------------------------
module tb_top;
	import gem_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int TARGET_ITEMS = 1900;
	// longest run of pixels sent for a cut-short frame
	localparam int TRUNC_MAX = 96;
	// an item without a result may still be in the front and queue
	localparam int SETTLE_CYCLES = 64;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [PIX_W-1:0]      s_tdata = '0;      // [7:0] pixel
	logic                  s_tuser = 1'b0;    // [0] kind: 1 pad item
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [PIX_W-1:0]      m_tdata;           // [7:0] edge_value
	logic                  m_tlast;           // frame_end
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int mismatches, pending, results_seen;
	int items_sent, cfg_writes, burst_left, stall_cycle;
	longint cycles;

	gradient_edge_magnitude_unit dut (.*);

	gem_scoreboard u_scoreboard (.*);

	initial begin
		forever #2 clk = ~clk;
	end

	// Timeout: stop a hung run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL gradient_edge_magnitude_unit");
			$finish;
		end
	end

	// Receiver: cycle through always-ready, random and mostly-stalled stretches.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready    <= 1'b0;
			stall_cycle <= 0;
		end else begin
			stall_cycle <= stall_cycle + 1;
			case ((stall_cycle / 300) % 3)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 1) == 1);
				default: m_tready <= ($urandom_range(0, 4) == 0);
			endcase
		end
	end

	// Hold one item on the stream until accepted; keep tvalid high afterwards
	// unless the burst ends, so back-to-back items never lower it.
	task automatic push_item(logic pad, logic [PIX_W-1:0] pix);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
				: $urandom_range(1, 8);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= pad;
		s_tdata  <= pix;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		burst_left--;
	endtask

	task automatic push_pixel();
		logic [PIX_W-1:0] pix;
		case ($urandom_range(0, 5))
			0: pix = PIX_ZERO;
			1: pix = PIX_MAX;
			default: pix = PIX_W'($urandom_range(0, 255));
		endcase
		// now and then a pad inside the frame, which counts as a black pixel
		push_item($urandom_range(0, 24) == 0, pix);
	endtask

	// Drop tvalid, drain all expected results, let the front settle.
	task automatic settle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the three registers back to back; lower valid only at the end.
	task automatic configure(logic mode, int unsigned width, int unsigned height);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_EDGE_MODE;
		cfg_data  <= {15'($urandom_range(0, 32767)), mode};
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= CFG_IMAGE_WIDTH;
		cfg_data  <= CFG_DATA_W'(width);
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= CFG_IMAGE_HEIGHT;
		cfg_data  <= CFG_DATA_W'(height);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cfg_writes += 3;
	endtask

	// One frame: pixels in raster order, then the flush run in Prewitt mode.
	// Truncate now and then; the next configuration restarts the frame anyway.
	task automatic push_frame(logic mode, int unsigned width, int unsigned height,
		bit truncate);
		int unsigned w, h, ticks;
		w = (width < 1) ? 1 : (width > MAX_WIDTH_DEF ? MAX_WIDTH_DEF : width);
		h = (height < 1) ? 1 : height;
		ticks = w * h;
		if (truncate) ticks = $urandom_range(1, (ticks > TRUNC_MAX) ? TRUNC_MAX : ticks);
		repeat (ticks) push_pixel();
		if (mode == MODE_PREWITT && !truncate) begin
			// mostly pads; a stray pixel during flush is consumed as a pad
			repeat (w + 1) push_item($urandom_range(0, 7) != 0,
				PIX_W'($urandom_range(0, 255)));
		end
		// pad items between frames are dropped
		repeat ($urandom_range(0, 2)) push_item(KIND_PAD, PIX_W'($urandom_range(0, 255)));
	endtask

	task automatic run_phase(logic mode, int unsigned width, int unsigned height,
		int frames, bit truncate);
		settle();
		configure(mode, width, height);
		repeat (frames) push_frame(mode, width, height, truncate);
	endtask

	initial begin
		logic        mode;
		int unsigned width, height;
		items_sent = 0;
		cfg_writes = 0;
		burst_left = 0;
		cycles     = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: idle pads, extremes, both modes, tiny and clamped sizes.
		push_item(KIND_PAD, PIX_MAX);
		run_phase(MODE_ROBERTS, 3, 2, 1, 0);
		run_phase(MODE_PREWITT, 3, 2, 1, 0);
		run_phase(MODE_ROBERTS, 0, 0, 2, 0);
		run_phase(MODE_PREWITT, 0, 0, 2, 0);
		run_phase(MODE_PREWITT, 1, 3, 1, 0);
		run_phase(MODE_ROBERTS, 2047, 1, 1, 0);
		run_phase(MODE_PREWITT, 2047, 1, 1, 1);
		run_phase(MODE_PREWITT, 2, 65535, 1, 1);

		// Random: mostly small whole frames, a few wide or broken ones.
		while (items_sent < TARGET_ITEMS) begin
			mode = 1'($urandom_range(0, 1));
			width = $urandom_range(1, 12);
			height = $urandom_range(1, 8);
			case ($urandom_range(0, 19))
				0: width = $urandom_range(0, 48);
				1: height = $urandom_range(0, 65535);
				default: ;
			endcase
			if (width > 24 || width == 0) height = 1;
			run_phase(mode, width, height, $urandom_range(1, 3),
				height > 8 || $urandom_range(0, 9) == 0);
		end
		settle();

		$display("%0d items in, %0d results checked, %0d register writes",
			items_sent, results_seen, cfg_writes);
		$display("covered Roberts and Prewitt frames, pads, flushes and clamped sizes");
		if (mismatches == 0 && pending == 0) begin
			$display("PASS gradient_edge_magnitude_unit");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, pending);
			$display("FAIL gradient_edge_magnitude_unit");
		end
		$finish;
	end

endmodule

>>> files.f
+incdir+design
design/gem_pkg.sv
design/gem_ram.sv
design/gem_front.sv
design/gem_queue.sv
design/gem_back.sv
design/gradient_edge_magnitude_unit.sv
design/gem_checker.sv
bench/gem_checker.sv
bench/tb_top.sv
